### rtl/arm_forward_kinematics_macros.svh
// Assertion macros shared by the arm forward kinematics RTL
`ifndef ARM_FORWARD_KINEMATICS_MACROS_SVH
`define ARM_FORWARD_KINEMATICS_MACROS_SVH

// Same-cycle implication, clocked on clk, disabled in reset
`define AFK_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset
`define AFK_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/afk_pkg.sv
// Package: widths, register indexes and CORDIC constants for the arm kinematics block
`default_nettype none

package afk_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int POS_BITS_DEF   = 16;

  localparam int LEN_BITS     = 14;
  localparam int CFG_IDX_BITS = 2;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_BITS-1:0] REG_UPPER_ARM   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FOREARM     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_HEIGHT = 2'd2;

  localparam logic [LEN_BITS-1:0] UPPER_ARM_RST   = 14'd9830;
  localparam logic [LEN_BITS-1:0] FOREARM_RST     = 14'd11010;
  localparam logic [LEN_BITS-1:0] BASE_HEIGHT_RST = 14'd8126;

  // CORDIC datapath: x,y in Q2.30 with guard bits, z in 2^-32 turn
  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
  localparam int SC_BITS      = 18;

  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

`default_nettype wire

### rtl/afk_joint_if.sv
// Joint angle channel: valid, ready and three binary angles
`default_nettype none

interface afk_joint_if #(
  parameter int ANGLE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [ANGLE_BITS-1:0] base_angle;
  logic [ANGLE_BITS-1:0] shoulder_angle;
  logic [ANGLE_BITS-1:0] elbow_angle;

  modport source (output valid, base_angle, shoulder_angle, elbow_angle, input ready);
  modport sink   (input valid, base_angle, shoulder_angle, elbow_angle, output ready);
endinterface

`default_nettype wire

### rtl/afk_pos_if.sv
// Tool position channel: valid, ready and three signed coordinates
`default_nettype none

interface afk_pos_if #(
  parameter int POS_BITS = 16
);
  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] pos_x;
  logic signed [POS_BITS-1:0] pos_y;
  logic signed [POS_BITS-1:0] pos_z;

  modport source (output valid, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

`default_nettype wire

### rtl/afk_cfg_if.sv
// Configuration write channel: valid, ready, register index and data
`default_nettype none

interface afk_cfg_if
  import afk_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [LEN_BITS-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/afk_cordic.sv
// Pipelined rotation-mode CORDIC: sine and cosine of a binary angle in Q1.15
`default_nettype none

module afk_cordic
  import afk_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [ANGLE_BITS-1:0]     angle,
  output logic signed [SC_BITS-1:0]      sin_q15,
  output logic signed [SC_BITS-1:0]      cos_q15
);

  localparam logic signed [CORDIC_W-1:0] ROUND_Q15 = CORDIC_W'(1 <<< 14);

  logic signed [CORDIC_W-1:0] x_s [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_s [0:CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] z_s [0:CORDIC_STEPS];
  logic                       flip_s [0:CORDIC_STEPS];

  logic [31:0] t_wide;
  logic [31:0] t_quad;
  logic [31:0] t_fold;
  logic        fold;

  // widen to a 32-bit angle and fold the left half plane onto the right
  always_comb begin
    t_wide = {angle, {(32-ANGLE_BITS){1'b0}}};
    t_quad = t_wide + 32'h4000_0000;
    fold   = t_quad[31];
    t_fold = fold ? (t_wide ^ 32'h8000_0000) : t_wide;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_s[0]    <= signed'({{(CORDIC_W-32){1'b0}}, CORDIC_GAIN_Q30});
      y_s[0]    <= '0;
      z_s[0]    <= signed'({{(CORDIC_W-32){t_fold[31]}}, t_fold});
      flip_s[0] <= fold;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    localparam logic signed [CORDIC_W-1:0] ATAN_I =
      signed'({{(CORDIC_W-32){1'b0}}, ATAN_TURN[i]});
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_s[i][CORDIC_W-1]) begin
          x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] - ATAN_I;
        end else begin
          x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
          y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
          z_s[i+1] <= z_s[i] + ATAN_I;
        end
        flip_s[i+1] <= flip_s[i];
      end
    end
  end

  logic signed [CORDIC_W-1:0] cos_rnd;
  logic signed [CORDIC_W-1:0] sin_rnd;

  // undo the fold, then round Q2.30 to Q1.15
  always_comb begin
    cos_rnd = ((flip_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS])
               + ROUND_Q15) >>> 15;
    sin_rnd = ((flip_s[CORDIC_STEPS] ? -y_s[CORDIC_STEPS] : y_s[CORDIC_STEPS])
               + ROUND_Q15) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q15 <= cos_rnd[SC_BITS-1:0];
      sin_q15 <= sin_rnd[SC_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/arm_forward_kinematics.sv
// Top level: forward kinematics pipeline of a yaw, shoulder and elbow arm
`default_nettype none

// Takes three joint angles per transfer and returns the saturated tool position
// (x, y, z in 2^-16 m). One item per cycle is accepted while the skid is empty.
// The pipe is made of the 24 stages of the three parallel CORDIC pipelines
// plus input, CORDIC seed, rounding, two multiply, sum and saturation stages.
// A skid register behind the output stage catches the result the sink refuses
// while the pipe moves on; input ready drops in the cycle after a waiting result
// is first refused and comes back in the cycle after the skid transfer. Link
// lengths are read in the first multiply stage and the base height two stages
// later, so write them only while no item is in flight.

`include "arm_forward_kinematics_macros.svh"

module arm_forward_kinematics
  import afk_pkg::*;
#(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int POS_BITS   = POS_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  afk_joint_if.sink joint,
  afk_pos_if.source pos,
  afk_cfg_if.sink   cfg
);

  localparam int NSTAGE = CORDIC_LAT + 5;
  localparam int LAST   = NSTAGE - 1;
  localparam int PW     = LEN_BITS + 1 + SC_BITS;
  localparam int RW     = PW + 1;
  localparam int MW     = RW + SC_BITS;

  localparam logic signed [PW-1:0] ROUND_Z = PW'(1 <<< 14);
  localparam logic signed [MW-1:0] ROUND_M = MW'(64'sd1 <<< 29);
  localparam logic signed [MW-1:0] POS_HI  = MW'((64'sd1 <<< (POS_BITS-1)) - 64'sd1);
  localparam logic signed [MW-1:0] POS_LO  = -POS_HI - MW'(1);

  function automatic logic [POS_BITS-1:0] sat(input logic signed [MW-1:0] v);
    logic signed [MW-1:0] c;
    c = v;
    if (v > POS_HI) c = POS_HI;
    if (v < POS_LO) c = POS_LO;
    return c[POS_BITS-1:0];
  endfunction

  // configuration registers
  logic [LEN_BITS-1:0] upper_arm_length;
  logic [LEN_BITS-1:0] forearm_length;
  logic [LEN_BITS-1:0] base_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_arm_length <= UPPER_ARM_RST;
      forearm_length   <= FOREARM_RST;
      base_height      <= BASE_HEIGHT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_UPPER_ARM:   upper_arm_length <= cfg.data;
        REG_FOREARM:     forearm_length   <= cfg.data;
        REG_BASE_HEIGHT: base_height      <= cfg.data;
        default: ;
      endcase
    end
  end

  // pipeline control: whole pipe moves while the skid is empty
  logic              en;
  logic [NSTAGE-1:0] vld;
  logic              skid_valid;

  assign en          = !skid_valid;
  assign joint.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], joint.valid};
    end
  end

  // input stage
  logic [ANGLE_BITS-1:0] q1;
  logic [ANGLE_BITS-1:0] q2;
  logic [ANGLE_BITS-1:0] q23;

  always_ff @(posedge clk) begin
    if (en) begin
      q1  <= joint.base_angle;
      q2  <= joint.shoulder_angle;
      q23 <= ANGLE_BITS'(joint.shoulder_angle + joint.elbow_angle);
    end
  end

  logic signed [SC_BITS-1:0] s1, c1, s2, c2, s23, c23;

  afk_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_q1 (
    .clk(clk), .en(en), .angle(q1), .sin_q15(s1), .cos_q15(c1)
  );
  afk_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_q2 (
    .clk(clk), .en(en), .angle(q2), .sin_q15(s2), .cos_q15(c2)
  );
  afk_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic_q23 (
    .clk(clk), .en(en), .angle(q23), .sin_q15(s23), .cos_q15(c23)
  );

  // link products
  logic signed [PW-1:0]      p_fc, p_us, p_fs, p_uc;
  logic signed [SC_BITS-1:0] c1_a, s1_a, c1_b, s1_b;
  logic signed [RW-1:0]      reach;
  logic signed [RW-1:0]      zsum;
  logic signed [MW-1:0]      mx, my;
  logic signed [RW-1:0]      zq;
  logic [POS_BITS-1:0]       out_x, out_y, out_z;

  logic signed [LEN_BITS:0]  lu_s, lf_s;
  logic signed [RW-1:0]      zsum_rnd;

  always_comb begin
    lu_s     = signed'({1'b0, upper_arm_length});
    lf_s     = signed'({1'b0, forearm_length});
    zsum_rnd = (zsum + RW'(ROUND_Z)) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_fc  <= lf_s * c23;
      p_us  <= lu_s * s2;
      p_fs  <= lf_s * s23;
      p_uc  <= lu_s * c2;
      c1_a  <= c1;
      s1_a  <= s1;

      reach <= RW'(p_fc) - RW'(p_us);
      zsum  <= RW'(p_fs) + RW'(p_uc);
      c1_b  <= c1_a;
      s1_b  <= s1_a;

      mx    <= reach * c1_b;
      my    <= reach * s1_b;
      zq    <= zsum_rnd + signed'({{(RW-LEN_BITS){1'b0}}, base_height});

      out_x <= sat((mx + ROUND_M) >>> 30);
      out_y <= sat((my + ROUND_M) >>> 30);
      out_z <= sat(MW'(zq));
    end
  end

  // skid: holds a result the sink did not take while the pipe moved on
  logic [POS_BITS-1:0] skid_x, skid_y, skid_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pos.ready) skid_valid <= 1'b0;
    end else if (vld[LAST] && !pos.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && vld[LAST] && !pos.ready) begin
      skid_x <= out_x;
      skid_y <= out_y;
      skid_z <= out_z;
    end
  end

  assign pos.valid = skid_valid | vld[LAST];
  assign pos.pos_x = skid_valid ? skid_x : out_x;
  assign pos.pos_y = skid_valid ? skid_y : out_y;
  assign pos.pos_z = skid_valid ? skid_z : out_z;

  `AFK_ASSERT_NEXT(a_stall_freezes, !en, $stable(vld), "pipeline moved during a stall")
  `AFK_ASSERT_NEXT(a_accept_enters, joint.valid && joint.ready, vld[0],
                   "accepted item did not enter the pipeline")
  `AFK_ASSERT_NEXT(a_skid_holds, skid_valid && !pos.ready,
                   skid_valid && $stable(skid_x) && $stable(skid_z),
                   "waiting result lost from skid")

endmodule

`default_nettype wire

### tb/tb_arm_forward_kinematics.sv
// Self-checking testbench for the arm forward kinematics pipeline
`timescale 1ns / 1ps

module tb_arm_forward_kinematics;
  import afk_pkg::*;

  typedef logic [ANGLE_BITS_DEF-1:0]      angle_t;
  typedef logic signed [POS_BITS_DEF-1:0] pos_t;
  typedef logic [LEN_BITS-1:0]            len_t;
  typedef logic [CFG_IDX_BITS-1:0]        cfg_idx_t;

  typedef struct packed {
    pos_t x;
    pos_t y;
    pos_t z;
  } tool_pos_t;

  // which fields of a table row are typed in rather than predicted
  localparam bit [2:0] PIN_NONE = 3'b000;
  localparam bit [2:0] PIN_Z    = 3'b100;
  localparam bit [2:0] PIN_XYZ  = 3'b111;

  // index with no register behind it; writes to it must change nothing
  localparam cfg_idx_t REG_SPARE = 2'd3;

  localparam int PIPE_LATENCY   = CORDIC_STEPS + 7;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 200;
  localparam len_t LEN_MAX      = len_t'((1 << LEN_BITS) - 1);

  typedef struct packed {
    bit       is_cfg;
    angle_t   q1;
    angle_t   q2;
    angle_t   q3;
    len_t     upper;
    len_t     fore;
    len_t     height;
    bit [2:0] pin;
    pos_t     px;
    pos_t     py;
    pos_t     pz;
  } stim_row_t;

  // cfg rows: upper arm, forearm, base height; item rows: three angles
  localparam stim_row_t DIRECTED_ROWS [28] = '{
    '{0, 'h0000, 'h0000, 'h0000, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{0, 'hFFFF, 'hFFFF, 'hFFFF, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{0, 'h4000, 'h4000, 'h4000, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{0, 'h8000, 'h8000, 'h8000, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{0, 'hC000, 'hC000, 'hC000, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{0, 'h2000, 'hE000, 'h2000, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{0, 'h3FFF, 'h4000, 'hBFFF, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{0, 'hC000, 'hC001, 'h3FFF, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{0, 'h1234, 'h8000, 'h8000, 0, 0, 0, PIN_NONE, 0, 0, 0},
    // zero links: the tool sits on the shoulder axis
    '{1, 0, 0, 0, 0, 0, 16383, PIN_NONE, 0, 0, 0},
    '{0, 'h0000, 'h0000, 'h0000, 0, 0, 0, PIN_XYZ, 0, 0, 16383},
    '{0, 'hFFFF, 'h4000, 'hC000, 0, 0, 0, PIN_XYZ, 0, 0, 16383},
    '{0, 'hA5A5, 'h5A5A, 'hFFFF, 0, 0, 0, PIN_XYZ, 0, 0, 16383},
    // longest links: straight up overflows z, full reach out and back
    '{1, 0, 0, 0, 16383, 16383, 16383, PIN_NONE, 0, 0, 0},
    '{0, 'h0000, 'h0000, 'h4000, 0, 0, 0, PIN_Z, 0, 0, 32767},
    '{0, 'h4000, 'h0000, 'h4000, 0, 0, 0, PIN_Z, 0, 0, 32767},
    '{0, 'h0000, 'hC000, 'h4000, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{0, 'h8000, 'hC000, 'h4000, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{0, 'h2000, 'hC000, 'h4000, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{0, 'h0000, 'h4000, 'h4000, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{1, 0, 0, 0, 0, 16383, 0, PIN_NONE, 0, 0, 0},
    '{0, 'h0000, 'h0000, 'h0000, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{0, 'hFFFF, 'h8000, 'h7FFF, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{1, 0, 0, 0, 16383, 0, 0, PIN_NONE, 0, 0, 0},
    '{0, 'h6000, 'h9000, 'h0000, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{0, 'hE000, 'h1000, 'hF000, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{1, 0, 0, 0, 0, 0, 0, PIN_NONE, 0, 0, 0},
    '{0, 'h1111, 'h2222, 'h3333, 0, 0, 0, PIN_XYZ, 0, 0, 0}
  };

  logic clk = 1'b0;
  logic rst;

  afk_joint_if #(.ANGLE_BITS(ANGLE_BITS_DEF)) joint_ch ();
  afk_pos_if   #(.POS_BITS(POS_BITS_DEF))     pos_ch ();
  afk_cfg_if                                  cfg_ch ();

  arm_forward_kinematics DUT (
    .clk   (clk),
    .rst   (rst),
    .joint (joint_ch),
    .pos   (pos_ch),
    .cfg   (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the link registers
  len_t upper_arm_len;
  len_t forearm_len;
  len_t base_height_len;

  tool_pos_t expected_pos_q [$];

  int mismatches;
  int results_checked;
  int items_sent;
  int directed_items;
  int link_settings;
  int reg_writes;
  int hold_requests;
  int burst_left;
  bit steady_feed;
  bit joint_offering;

  // sin and cos of a binary angle in Q1.15, rotation-mode CORDIC
  function automatic void angle_sin_cos(input angle_t ang, output longint sn,
                                        output longint cs);
    logic [31:0] turn;
    logic [31:0] probe;
    bit          flip;
    longint      x, y, z, nx;
    int          i;
    turn  = {ang, {(32 - ANGLE_BITS_DEF){1'b0}}};
    probe = turn + 32'h4000_0000;
    flip  = probe[31];
    // fold the left half-plane onto the right one, undo the sign at the end
    if (flip) turn = turn - 32'h8000_0000;
    x = longint'(CORDIC_GAIN_Q30);
    y = 0;
    z = longint'($signed(turn));
    for (i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ATAN_TURN[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ATAN_TURN[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = (x + 64'sd16384) >>> 15;
    sn = (y + 64'sd16384) >>> 15;
  endfunction

  function automatic pos_t clamp_pos(input longint v);
    longint top;
    top = (64'sd1 <<< (POS_BITS_DEF - 1)) - 1;
    if (v > top) return pos_t'(top);
    if (v < -top - 1) return pos_t'(-top - 1);
    return pos_t'(v);
  endfunction

  function automatic tool_pos_t predict_tool_pos(input angle_t q1, input angle_t q2,
                                                 input angle_t q3);
    angle_t    q23;
    longint    s1, c1, s2, c2, s23, c23, lu, lf, reach;
    tool_pos_t p;
    q23 = q2 + q3;
    angle_sin_cos(q1, s1, c1);
    angle_sin_cos(q2, s2, c2);
    angle_sin_cos(q23, s23, c23);
    lu    = longint'(upper_arm_len);
    lf    = longint'(forearm_len);
    reach = lf * c23 - lu * s2;
    p.x = clamp_pos((reach * c1 + (64'sd1 <<< 29)) >>> 30);
    p.y = clamp_pos((reach * s1 + (64'sd1 <<< 29)) >>> 30);
    p.z = clamp_pos(((lf * s23 + lu * c2 + 64'sd16384) >>> 15) + longint'(base_height_len));
    return p;
  endfunction

  function automatic void check_field(input string name, input pos_t got, input pos_t want);
    if (got !== want) begin
      mismatches++;
      $display("%0t: pos_%s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic angle_t pick_angle();
    case ($urandom_range(0, 5))
      0: return angle_t'($urandom_range(0, 3)) << (ANGLE_BITS_DEF - 2);
      // a few steps either side of a quadrant boundary
      1: return (angle_t'($urandom_range(0, 3)) << (ANGLE_BITS_DEF - 2))
                + angle_t'($urandom_range(0, 8)) - angle_t'(4);
      default: return angle_t'($urandom());
    endcase
  endfunction

  function automatic len_t pick_length();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return LEN_MAX;
      default: return len_t'($urandom());
    endcase
  endfunction

  // shadow registers follow each accepted write
  always @(posedge clk) begin
    if (rst) begin
      upper_arm_len   <= UPPER_ARM_RST;
      forearm_len     <= FOREARM_RST;
      base_height_len <= BASE_HEIGHT_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      reg_writes <= reg_writes + 1;
      case (cfg_ch.index)
        REG_UPPER_ARM:   upper_arm_len   <= cfg_ch.data;
        REG_FOREARM:     forearm_len     <= cfg_ch.data;
        REG_BASE_HEIGHT: base_height_len <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    tool_pos_t want;
    if (!rst && pos_ch.valid && pos_ch.ready) begin
      if (expected_pos_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got x=%0d y=%0d z=%0d",
                 $time, pos_ch.pos_x, pos_ch.pos_y, pos_ch.pos_z);
      end else begin
        want = expected_pos_q.pop_front();
        check_field("x", pos_ch.pos_x, want.x);
        check_field("y", pos_ch.pos_y, want.y);
        check_field("z", pos_ch.pos_z, want.z);
        results_checked++;
      end
    end
  end

  // receiver back-pressure: stall rate changes now and then, long holds on request
  initial begin
    int stall_pct;
    int mode_left;
    int hold_left;
    int holds_served;
    stall_pct    = 0;
    mode_left    = 0;
    hold_left    = 0;
    holds_served = 0;
    pos_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        hold_left    = RX_HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 15;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        mode_left = $urandom_range(16, 400);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        pos_ch.ready <= 1'b0;
      end else begin
        pos_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // offer one set of angles and keep valid up until the transfer
  task automatic send_angles(input angle_t q1, input angle_t q2, input angle_t q3,
                             input bit [2:0] pin, input tool_pos_t pinned);
    tool_pos_t want;
    int        gap;
    joint_ch.valid          <= 1'b1;
    joint_ch.base_angle     <= q1;
    joint_ch.shoulder_angle <= q2;
    joint_ch.elbow_angle    <= q3;
    joint_offering = 1'b1;
    @(posedge clk);
    while (!joint_ch.ready) @(posedge clk);
    want = predict_tool_pos(q1, q2, q3);
    if (pin[0]) want.x = pinned.x;
    if (pin[1]) want.y = pinned.y;
    if (pin[2]) want.z = pinned.z;
    expected_pos_q.push_back(want);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 48);
      gap = (steady_feed || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        joint_ch.valid <= 1'b0;
        joint_offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    if (joint_offering) begin
      joint_ch.valid <= 1'b0;
      joint_offering = 1'b0;
    end
    while (expected_pos_q.size() != 0) @(posedge clk);
  endtask

  // valid stays up between back-to-back writes and drops after the last one
  task automatic write_reg(input cfg_idx_t idx, input len_t val, input bit last);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (last) cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_links(input len_t upper, input len_t fore, input len_t height,
                             input bit stray);
    wait_drained();
    write_reg(REG_UPPER_ARM, upper, 1'b0);
    write_reg(REG_FOREARM, fore, 1'b0);
    write_reg(REG_BASE_HEIGHT, height, !stray);
    if (stray) write_reg(REG_SPARE, ~height, 1'b1);
    link_settings++;
  endtask

  initial begin
    #2_000_000;
    $display("arm_forward_kinematics verification failed");
    $finish;
  end

  initial begin
    stim_row_t row;
    angle_t    q2;
    angle_t    q3;
    int        phase;
    int        n;
    mismatches      = 0;
    results_checked = 0;
    items_sent      = 0;
    link_settings   = 0;
    reg_writes      = 0;
    hold_requests   = 0;
    burst_left      = 0;
    steady_feed     = 1'b0;
    joint_offering  = 1'b0;
    rst                     <= 1'b1;
    joint_ch.valid          <= 1'b0;
    joint_ch.base_angle     <= '0;
    joint_ch.shoulder_angle <= '0;
    joint_ch.elbow_angle    <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.index            <= REG_UPPER_ARM;
    cfg_ch.data             <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (row.is_cfg)
        apply_links(row.upper, row.fore, row.height, 1'b1);
      else
        send_angles(row.q1, row.q2, row.q3, row.pin, '{row.px, row.py, row.pz});
    end
    directed_items = items_sent;

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      apply_links(pick_length(), pick_length(), pick_length(), $urandom_range(0, 1) == 1);
      // one phase keeps feeding into a long receiver hold so the input stalls
      steady_feed = (phase == 2);
      if (steady_feed) hold_requests++;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        q2 = pick_angle();
        q3 = pick_angle();
        // elbow folded back onto the shoulder so q2+q3 wraps near zero
        if ($urandom_range(0, 4) == 0) q3 = angle_t'($urandom_range(0, 4)) - q2;
        send_angles(pick_angle(), q2, q3, PIN_NONE, '0);
      end
      steady_feed = 1'b0;
    end

    wait_drained();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    $display("Covered %0d joint transfers (%0d directed) over %0d link settings;",
             items_sent, directed_items, link_settings);
    $display("%0d register writes, %0d positions checked, %0d mismatches.",
             reg_writes, results_checked, mismatches);
    if (mismatches == 0)
      $display("arm_forward_kinematics verification clean");
    else
      $display("arm_forward_kinematics verification failed");
    $finish;
  end

endmodule
